// File: sv/ptw_pkg.sv
// Shared types, field widths and codes of the page table walker.
package ptw_pkg;

  localparam int unsigned VA_W    = 48;
  localparam int unsigned PA_W    = 52;
  localparam int unsigned ENTRY_W = 64;
  localparam int unsigned IDX_W   = 9;
  localparam int unsigned CFG_AW  = 4;
  localparam int unsigned CFG_DW  = 64;

  localparam logic OP_START   = 1'b0;
  localparam logic OP_DELIVER = 1'b1;

  localparam logic [1:0] KIND_READ  = 2'd0;
  localparam logic [1:0] KIND_DONE  = 2'd1;
  localparam logic [1:0] KIND_FAULT = 2'd2;

  localparam logic [1:0] SIZE_4K = 2'd0;
  localparam logic [1:0] SIZE_2M = 2'd1;
  localparam logic [1:0] SIZE_1G = 2'd2;

  localparam logic [1:0] LVL_PT   = 2'd0;
  localparam logic [1:0] LVL_PD   = 2'd1;
  localparam logic [1:0] LVL_PDPT = 2'd2;
  localparam logic [1:0] LVL_PML4 = 2'd3;

  localparam int unsigned BIT_PRESENT = 0;
  localparam int unsigned BIT_WRITE   = 1;
  localparam int unsigned BIT_USER    = 2;
  localparam int unsigned BIT_PCD     = 4;
  localparam int unsigned BIT_HUGE    = 7;
  localparam int unsigned BIT_NX      = 63;

  localparam logic REG_TABLE_ROOT = 1'b0;

  typedef struct packed {
    logic                 operation;
    logic [VA_W-1:0]      virt_addr;
    logic [ENTRY_W-1:0]   entry_data;
  } req_t;

  typedef struct packed {
    logic [1:0]      kind;
    logic [PA_W-1:0] read_addr;
    logic [PA_W-1:0] phys_addr;
    logic [1:0]      map_size;
    logic            can_write;
    logic            user_access;
    logic            can_execute;
    logic            uncached;
  } result_t;

  typedef struct packed {
    logic            walk_busy;
    logic [1:0]      walk_level;
    logic [VA_W-1:0] saved_vaddr;
  } walk_state_t;

endpackage

// File: sv/ptw_if.sv
// Handshake channel interfaces for walker requests and walker results.
interface ptw_req_if;
  logic                          valid;
  logic                          ready;
  logic                          operation;
  logic [ptw_pkg::VA_W-1:0]      virt_addr;
  logic [ptw_pkg::ENTRY_W-1:0]   entry_data;

  modport source (output valid, operation, virt_addr, entry_data, input ready);
  modport sink (input valid, operation, virt_addr, entry_data, output ready);
endinterface

interface ptw_res_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [ptw_pkg::PA_W-1:0]   read_addr;
  logic [ptw_pkg::PA_W-1:0]   phys_addr;
  logic [1:0]                 map_size;
  logic                       can_write;
  logic                       user_access;
  logic                       can_execute;
  logic                       uncached;

  modport source (output valid, kind, read_addr, phys_addr, map_size, can_write,
                  user_access, can_execute, uncached, input ready);
  modport sink (input valid, kind, read_addr, phys_addr, map_size, can_write,
                user_access, can_execute, uncached, output ready);
endinterface

// File: sv/ptw_step.sv
// Combinational walk step: one request against the walk state gives the result and next state.
module ptw_step (
  input  ptw_pkg::req_t        req,
  input  ptw_pkg::walk_state_t state,
  input  logic [ptw_pkg::PA_W-1:0] table_root,
  output logic                 res_valid,
  output ptw_pkg::result_t     res,
  output ptw_pkg::walk_state_t state_nxt
);
  import ptw_pkg::*;

  logic [VA_W-1:0]    va;
  logic [1:0]         lvl;
  logic [PA_W-13:0]   base_frame;
  logic [IDX_W-1:0]   idx;
  logic [ENTRY_W-1:0] e;
  logic               present;
  logic               huge;
  logic               do_read;
  logic               do_leaf;
  logic [1:0]         leaf_size;
  logic [PA_W-1:0]    leaf_addr;

  assign e       = req.entry_data;
  assign present = e[BIT_PRESENT];
  assign huge    = e[BIT_HUGE];

  always_comb begin
    va        = state.saved_vaddr;
    lvl       = state.walk_level;
    base_frame = e[PA_W-1:12];
    do_read   = 1'b0;
    do_leaf   = 1'b0;
    leaf_size = SIZE_4K;
    res_valid = 1'b0;
    state_nxt = state;
    if (req.operation == OP_START) begin
      va         = req.virt_addr;
      lvl        = LVL_PML4;
      base_frame = table_root[PA_W-1:12];
      do_read    = 1'b1;
      res_valid  = 1'b1;
      state_nxt.walk_busy   = 1'b1;
      state_nxt.walk_level  = LVL_PML4;
      state_nxt.saved_vaddr = req.virt_addr;
    end else if (state.walk_busy) begin
      res_valid = 1'b1;
      unique case (state.walk_level)
        LVL_PML4: begin
          do_read = present && !huge;
          lvl     = LVL_PDPT;
        end
        LVL_PDPT: begin
          do_leaf   = huge;
          leaf_size = SIZE_1G;
          do_read   = !huge && present;
          lvl       = LVL_PD;
        end
        LVL_PD: begin
          do_leaf   = huge;
          leaf_size = SIZE_2M;
          do_read   = !huge && present;
          lvl       = LVL_PT;
        end
        default: begin
          do_leaf   = 1'b1;
          leaf_size = SIZE_4K;
        end
      endcase
      if (do_read) begin
        state_nxt.walk_level = lvl;
      end else begin
        state_nxt.walk_busy  = 1'b0;
        state_nxt.walk_level = LVL_PT;
      end
    end
  end

  always_comb begin
    unique case (lvl)
      LVL_PT:   idx = va[12 +: IDX_W];
      LVL_PD:   idx = va[21 +: IDX_W];
      LVL_PDPT: idx = va[30 +: IDX_W];
      default:  idx = va[39 +: IDX_W];
    endcase
  end

  always_comb begin
    unique case (leaf_size)
      SIZE_1G: leaf_addr = {e[PA_W-1:30], va[29:0]};
      SIZE_2M: leaf_addr = {e[PA_W-1:21], va[20:0]};
      default: leaf_addr = {e[PA_W-1:12], va[11:0]};
    endcase
  end

  always_comb begin
    res = '0;
    if (do_read) begin
      res.kind      = KIND_READ;
      res.read_addr = {base_frame, idx, 3'b000};
    end else if (do_leaf && present) begin
      res.kind        = KIND_DONE;
      res.phys_addr   = leaf_addr;
      res.map_size    = leaf_size;
      res.can_write   = e[BIT_WRITE];
      res.user_access = e[BIT_USER];
      res.can_execute = !e[BIT_NX];
      res.uncached    = e[BIT_PCD];
    end else begin
      res.kind = KIND_FAULT;
    end
  end

endmodule

// File: sv/page_table_walker_core.sv
// Top level of the four-level page table walker with its configuration port.
// The walker takes one request per cycle unless an unaccepted result holds it: a start, or a
// table entry returned for the last read it asked for. Each request passes through an input
// register, one step of walk logic and a result register; a new request can be taken before
// the result of the last one is accepted. A start or a delivery during a walk gives exactly
// one result (a read request, a completed translation or a fault); a delivery with no walk in
// progress gives none. A start during a walk abandons it. The table root is written through the
// configuration port at byte address 0 and must only be changed while the walker is idle.
module page_table_walker_core (
  input  logic                         clk,
  input  logic                         rst_n,
  ptw_req_if.sink                      in_req,
  ptw_res_if.source                    out_res,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [ptw_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [ptw_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [ptw_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import ptw_pkg::*;

  logic [PA_W-1:0] table_root_r;
  logic            cfg_sel_root;

  req_t            s1_req_r;
  logic            s1_valid_r;
  logic            s1_go;
  walk_state_t     state_r;
  walk_state_t     state_nxt;
  logic            res_valid;
  result_t         res;
  result_t         out_r;
  logic            out_valid_r;
  logic            out_valid_nxt;

  assign cfg_pready   = 1'b1;
  assign cfg_sel_root = cfg_paddr[CFG_AW-1] == REG_TABLE_ROOT;
  assign cfg_prdata   = cfg_sel_root ? {{(CFG_DW-PA_W){1'b0}}, table_root_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_root_r <= '0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_sel_root) begin
      table_root_r <= cfg_pwdata[PA_W-1:0];
    end
  end

  ptw_step u_step (
    .req        (s1_req_r),
    .state      (state_r),
    .table_root (table_root_r),
    .res_valid  (res_valid),
    .res        (res),
    .state_nxt  (state_nxt)
  );

  assign s1_go        = s1_valid_r && (!res_valid || !out_valid_r || out_res.ready);
  assign in_req.ready = !s1_valid_r || s1_go;

  always_comb begin
    if (s1_go && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_res.ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= '0;
    end else begin
      if (in_req.ready) begin
        s1_valid_r <= in_req.valid;
      end
      out_valid_r <= out_valid_nxt;
      if (s1_go) begin
        state_r <= state_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_req.valid && in_req.ready) begin
      s1_req_r.operation  <= in_req.operation;
      s1_req_r.virt_addr  <= in_req.virt_addr;
      s1_req_r.entry_data <= in_req.entry_data;
    end
    if (s1_go && res_valid) begin
      out_r <= res;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.kind        = out_r.kind;
  assign out_res.read_addr   = out_r.read_addr;
  assign out_res.phys_addr   = out_r.phys_addr;
  assign out_res.map_size    = out_r.map_size;
  assign out_res.can_write   = out_r.can_write;
  assign out_res.user_access = out_r.user_access;
  assign out_res.can_execute = out_r.can_execute;
  assign out_res.uncached    = out_r.uncached;

endmodule

// File: dv/tb_page_table_walker_core.sv
// Self-checking testbench of the page table walker core with directed and random walks.
`timescale 1ns / 100ps

module tb_page_table_walker_core;
  import ptw_pkg::*;

  localparam int unsigned REQS_PER_PHASE = 500;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned SETTLE         = 8;
  localparam logic [CFG_AW-1:0] ROOT_ADDR = CFG_AW'(8 * REG_TABLE_ROOT);

  localparam logic [ENTRY_W-1:0] E_PRESENT = 64'h1 << BIT_PRESENT;
  localparam logic [ENTRY_W-1:0] E_HUGE    = 64'h1 << BIT_HUGE;
  localparam logic [ENTRY_W-1:0] E_NX      = 64'h1 << BIT_NX;
  localparam logic [ENTRY_W-1:0] E_ALL     = '1;

  class walk_tracker;
    logic [PA_W-1:0] root;
    bit              busy;
    logic [1:0]      level;
    logic [VA_W-1:0] vaddr;
    result_t         pending[$];
    int unsigned     errors;

    function new();
      root   = '0;
      busy   = 1'b0;
      level  = LVL_PT;
      vaddr  = '0;
      errors = 0;
    endfunction

    function void check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
      if (exp_val !== act_val) begin
        $error("%s: expected %h, actual %h", name, exp_val, act_val);
        errors++;
      end
    endfunction

    function result_t entry_read(logic [ENTRY_W-1:0] base, logic [1:0] lvl);
      result_t r;
      logic [IDX_W-1:0] idx;
      r = '0;
      idx = IDX_W'(vaddr >> (12 + 9 * lvl));
      r.kind = KIND_READ;
      r.read_addr = {base[PA_W-1:12], idx, 3'b000};
      return r;
    endfunction

    function result_t walk_fault();
      result_t r;
      r = '0;
      r.kind = KIND_FAULT;
      busy = 1'b0;
      level = LVL_PT;
      return r;
    endfunction

    function result_t walk_leaf(logic [ENTRY_W-1:0] e, logic [1:0] size);
      result_t r;
      if (!e[BIT_PRESENT]) return walk_fault();
      r = '0;
      r.kind = KIND_DONE;
      r.map_size = size;
      case (size)
        SIZE_1G: r.phys_addr = {e[PA_W-1:30], vaddr[29:0]};
        SIZE_2M: r.phys_addr = {e[PA_W-1:21], vaddr[20:0]};
        default: r.phys_addr = {e[PA_W-1:12], vaddr[11:0]};
      endcase
      r.can_write   = e[BIT_WRITE];
      r.user_access = e[BIT_USER];
      r.can_execute = ~e[BIT_NX];
      r.uncached    = e[BIT_PCD];
      busy = 1'b0;
      level = LVL_PT;
      return r;
    endfunction

    // Returns whether the request causes a result.
    function bit note_request(req_t q);
      result_t r;
      logic [ENTRY_W-1:0] e;
      e = q.entry_data;
      if (q.operation == OP_START) begin
        vaddr = q.virt_addr;
        busy  = 1'b1;
        level = LVL_PML4;
        r = entry_read({12'b0, root}, LVL_PML4);
      end else if (!busy) begin
        return 1'b0;
      end else begin
        case (level)
          LVL_PML4: begin
            if (!e[BIT_PRESENT] || e[BIT_HUGE]) begin
              r = walk_fault();
            end else begin
              level = LVL_PDPT;
              r = entry_read(e, LVL_PDPT);
            end
          end
          LVL_PDPT, LVL_PD: begin
            if (e[BIT_HUGE]) begin
              r = walk_leaf(e, (level == LVL_PDPT) ? SIZE_1G : SIZE_2M);
            end else if (!e[BIT_PRESENT]) begin
              r = walk_fault();
            end else begin
              level = level - 2'd1;
              r = entry_read(e, level);
            end
          end
          default: r = walk_leaf(e, SIZE_4K);
        endcase
      end
      pending.push_back(r);
      return 1'b1;
    endfunction

    function void check_result(result_t act);
      result_t exp_r;
      if (pending.size() == 0) begin
        $error("result with no request outstanding: kind %h", act.kind);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      check_field("kind", exp_r.kind, act.kind);
      check_field("read_addr", exp_r.read_addr, act.read_addr);
      check_field("phys_addr", exp_r.phys_addr, act.phys_addr);
      check_field("map_size", exp_r.map_size, act.map_size);
      check_field("can_write", exp_r.can_write, act.can_write);
      check_field("user_access", exp_r.user_access, act.user_access);
      check_field("can_execute", exp_r.can_execute, act.can_execute);
      check_field("uncached", exp_r.uncached, act.uncached);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_psel;
  logic cfg_penable;
  logic cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  ptw_req_if req_ch ();
  ptw_res_if res_ch ();

  walk_tracker tracker;
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_request = 1'b0;
  bit          hold_started = 1'b0;
  int unsigned hold_left = 0;
  int unsigned idle_cycles = 0;

  page_table_walker_core i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_req      (req_ch),
    .out_res     (res_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    if (hold_request && !hold_started) begin
      hold_started = 1'b1;
      hold_left = LONG_HOLD;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin : result_monitor
    result_t act;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      act = '{kind: res_ch.kind, read_addr: res_ch.read_addr, phys_addr: res_ch.phys_addr,
              map_size: res_ch.map_size, can_write: res_ch.can_write,
              user_access: res_ch.user_access, can_execute: res_ch.can_execute,
              uncached: res_ch.uncached};
      tracker.check_result(act);
    end
  end

  always @(posedge clk) begin
    if ((req_ch.valid && req_ch.ready) || (res_ch.valid && res_ch.ready) || cfg_psel) begin
      idle_cycles = 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles++;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic req_t start_of(logic [VA_W-1:0] va);
    return '{operation: OP_START, virt_addr: va, entry_data: rand64()};
  endfunction

  function automatic req_t entry_of(logic [ENTRY_W-1:0] e);
    return '{operation: OP_DELIVER, virt_addr: VA_W'(rand64()), entry_data: e};
  endfunction

  function automatic logic [ENTRY_W-1:0] shaped_entry(logic [1:0] lvl);
    logic [ENTRY_W-1:0] e;
    e = rand64();
    e[BIT_PRESENT] = ($urandom_range(99) < 92);
    case (lvl)
      LVL_PML4:         e[BIT_HUGE] = ($urandom_range(99) < 5);
      LVL_PDPT, LVL_PD: e[BIT_HUGE] = ($urandom_range(99) < 30);
      default: ;
    endcase
    return e;
  endfunction

  task automatic send_request(req_t q, output bit counted);
    while ($urandom_range(99) < send_idle_pct) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid      <= 1'b1;
    req_ch.operation  <= q.operation;
    req_ch.virt_addr  <= q.virt_addr;
    req_ch.entry_data <= q.entry_data;
    do @(posedge clk); while (!req_ch.ready);
    counted = tracker.note_request(q);
  endtask

  task automatic cfg_access(bit wr, logic [CFG_DW-1:0] wdata, output logic [CFG_DW-1:0] rdata);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= ROOT_ADDR;
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    rdata = cfg_prdata;
  endtask

  task automatic set_root(logic [CFG_DW-1:0] value);
    logic [CFG_DW-1:0] rdata;
    cfg_access(1'b1, value, rdata);
    tracker.root = value[PA_W-1:0];
    cfg_access(1'b0, '0, rdata);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    tracker.check_field("table_root", {12'b0, tracker.root}, rdata);
  endtask

  task automatic drain();
    req_ch.valid <= 1'b0;
    while (tracker.pending.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic random_walk(output int unsigned n);
    bit counted;
    n = 0;
    if ($urandom_range(99) < 4) begin
      send_request(entry_of(rand64()), counted);
      n += counted;
    end
    send_request(start_of(VA_W'(rand64())), counted);
    n += counted;
    while (tracker.busy) begin
      if ($urandom_range(99) < 3) break;
      send_request(entry_of(shaped_entry(tracker.level)), counted);
      n += counted;
    end
  endtask

  initial begin
    req_t        plan[$];
    bit          counted;
    bit          hold_done;
    int unsigned done_reqs;
    int unsigned n;

    tracker = new();
    rst_n             <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.operation  <= OP_START;
    req_ch.virt_addr  <= '0;
    req_ch.entry_data <= '0;
    cfg_psel          <= 1'b0;
    cfg_penable       <= 1'b0;
    cfg_pwrite        <= 1'b0;
    cfg_paddr         <= '0;
    cfg_pwdata        <= '0;
    hold_done = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    set_root(E_ALL);
    plan = '{
      entry_of(E_ALL),
      start_of('0), entry_of(E_ALL & ~E_PRESENT),
      start_of('1), entry_of(E_ALL),
      start_of('1), entry_of(E_ALL & ~E_HUGE), entry_of(E_HUGE),
      start_of(48'h8040_2010_0abc), entry_of(E_ALL & ~E_HUGE), entry_of(E_ALL),
      start_of('1), entry_of(E_ALL & ~E_HUGE), entry_of('0),
      start_of(48'h7fff_ffff_ffff), entry_of(E_PRESENT), entry_of(E_PRESENT),
      entry_of(E_HUGE | E_PRESENT | E_NX),
      start_of('0),
      start_of('1), entry_of(E_ALL & ~E_HUGE), entry_of(E_ALL & ~E_HUGE),
      entry_of(E_ALL & ~E_HUGE), entry_of(E_HUGE | E_PRESENT)
    };
    foreach (plan[i]) send_request(plan[i], counted);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      case (ph)
        0: set_root('0);
        1: set_root(rand64());
        2: set_root(64'h000f_ffff_ffff_f000);
        default: set_root(rand64());
      endcase
      send_idle_pct  = (ph == 1) ? 64 : (ph == 3) ? 27 : 0;
      recv_stall_pct = (ph == 2) ? 64 : (ph == 3) ? 27 : 0;
      done_reqs = 0;
      while (done_reqs < REQS_PER_PHASE) begin
        if (ph == 0 && !hold_done && done_reqs >= REQS_PER_PHASE / 2) begin
          hold_request = 1'b1;
          hold_done = 1'b1;
        end
        random_walk(n);
        done_reqs += n;
      end
    end

    drain();
    if (tracker.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
sv/ptw_pkg.sv
sv/ptw_if.sv
sv/ptw_step.sv
sv/page_table_walker_core.sv
dv/tb_page_table_walker_core.sv
